// File: rtl/msbrm_pkg.sv
// ----------------------------------------------------------------------------
// msbrm_pkg
// Shared types and codes for the buffer ring manager.
// ----------------------------------------------------------------------------
package msbrm_pkg;

    // operation codes (request tuser)
    localparam logic [2:0] OP_REQ_WRITE = 3'd0;
    localparam logic [2:0] OP_FIN_WRITE = 3'd1;
    localparam logic [2:0] OP_ORD_READ  = 3'd2;
    localparam logic [2:0] OP_LAT_READ  = 3'd3;
    localparam logic [2:0] OP_FIN_READ  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_INACTIVE = 2'd3;

    // register index
    localparam logic REG_SLOT_BYTES = 1'b0;

    localparam logic [15:0] SLOT_BYTES_RESET = 16'd256;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } fsm_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch the accepted request
        logic rd_en;    // registered slot table read
        logic commit;   // apply state update, load result register
    } dp_cmd_t;

    typedef struct packed {
        logic        jumped_over;
        logic [2:0]  remaining;
        logic [31:0] read_time;
        logic [15:0] read_length;
        logic [18:0] base_address;
        logic [2:0]  slot;
        logic [1:0]  status;
    } result_t;

endpackage

// File: rtl/msbrm_ctrl.sv
// ----------------------------------------------------------------------------
// msbrm_ctrl
// Sequencer: accept, table read, execute, result register occupancy.
// ----------------------------------------------------------------------------
module msbrm_ctrl
    import msbrm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_commit;

    assign can_commit = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (can_commit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            S_EXEC:
            begin
                if (can_commit)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/msbrm_datapath.sv
// ----------------------------------------------------------------------------
// msbrm_datapath
// Ring indices, busy and fresh flags, slot length/stamp tables, result reg.
// ----------------------------------------------------------------------------
module msbrm_datapath
    import msbrm_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [2:0]  op,
    input  logic [15:0] write_length,
    input  logic [31:0] write_time,
    input  logic [15:0] slot_bytes,
    output result_t     result
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [IDX_W:0]   NSL      = (IDX_W+1)'(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        next_slot = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    // latched request
    logic [2:0]  op_reg;
    logic [15:0] len_reg;
    logic [31:0] time_reg;

    // ring state
    logic [IDX_W-1:0]     wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     lat_idx_reg, lat_idx_next;
    logic                 lat_vld_reg, lat_vld_next;
    logic                 wbusy_reg, wbusy_next;
    logic                 rbusy_reg, rbusy_next;
    logic [NUM_SLOTS-1:0] fresh_reg, fresh_next;
    logic [NUM_SLOTS-1:0] len_vld_reg, len_vld_next;
    logic [NUM_SLOTS-1:0] time_vld_reg, time_vld_next;

    // slot tables
    logic [15:0]      len_mem  [NUM_SLOTS];
    logic [31:0]      time_mem [NUM_SLOTS];
    logic [15:0]      len_q_reg;
    logic [31:0]      time_q_reg;
    logic             len_q_vld_reg;
    logic             time_q_vld_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             len_we, time_we;

    logic [IDX_W-1:0]       sel_idx;
    logic [IDX_W+15:0]      base_prod;
    logic [IDX_W:0]         rem_sum, rem_val;
    result_t                res_next;
    result_t                result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            len_reg  <= write_length;
            time_reg <= write_time;
        end
    end

    // table read address: latest read reads the latest slot, others the read slot
    assign rd_addr = (op_reg == OP_LAT_READ) ? lat_idx_reg : rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[wr_idx_reg] <= len_reg;
        if (time_we)
            time_mem[wr_idx_reg] <= time_reg;
        if (cmd.rd_en)
        begin
            len_q_reg      <= len_mem[rd_addr];
            time_q_reg     <= time_mem[rd_addr];
            len_q_vld_reg  <= len_vld_reg[rd_addr];
            time_q_vld_reg <= time_vld_reg[rd_addr];
        end
    end

    // distance from read to write slot, less the one being released
    assign rem_sum = {1'b0, wr_idx_reg} + NSL - {1'b0, rd_idx_reg} - 1'b1;
    assign rem_val = (rem_sum >= NSL) ? rem_sum - NSL : rem_sum;

    always_comb
    begin
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        lat_idx_next  = lat_idx_reg;
        lat_vld_next  = lat_vld_reg;
        wbusy_next    = wbusy_reg;
        rbusy_next    = rbusy_reg;
        fresh_next    = fresh_reg;
        len_vld_next  = len_vld_reg;
        time_vld_next = time_vld_reg;
        len_we        = 1'b0;
        time_we       = 1'b0;
        sel_idx       = wr_idx_reg;
        res_next      = '0;
        res_next.status = ST_INACTIVE;

        case (op_reg)
            OP_REQ_WRITE:
            begin
                if (wbusy_reg)
                    res_next.status = ST_BUSY;
                else
                begin
                    if ((wr_idx_reg == rd_idx_reg) && rbusy_reg)
                    begin
                        wr_idx_next          = next_slot(wr_idx_reg);
                        res_next.jumped_over = 1'b1;
                    end
                    wbusy_next      = 1'b1;
                    sel_idx         = wr_idx_next;
                    res_next.status = ST_OK;
                    res_next.slot   = 3'(wr_idx_next);
                end
            end
            OP_FIN_WRITE:
            begin
                if (wbusy_reg)
                begin
                    len_we                   = cmd.commit;
                    len_vld_next[wr_idx_reg] = 1'b1;
                    if (len_reg != 16'd0)
                    begin
                        fresh_next[wr_idx_reg]    = 1'b1;
                        time_we                   = cmd.commit;
                        time_vld_next[wr_idx_reg] = 1'b1;
                        lat_idx_next              = wr_idx_reg;
                        lat_vld_next              = 1'b1;
                        wr_idx_next               = next_slot(wr_idx_reg);
                    end
                    else
                        fresh_next[wr_idx_reg] = 1'b0;
                    wbusy_next      = 1'b0;
                    res_next.status = ST_OK;
                    res_next.slot   = 3'(wr_idx_reg);
                end
            end
            OP_ORD_READ:
            begin
                sel_idx = rd_idx_reg;
                if (rbusy_reg)
                    res_next.status = ST_BUSY;
                else if (rd_idx_reg == wr_idx_reg)
                    res_next.status = ST_EMPTY;
                else
                begin
                    res_next.status      = ST_OK;
                    res_next.slot        = 3'(rd_idx_reg);
                    res_next.read_length = len_q_vld_reg ? len_q_reg : 16'd0;
                    res_next.read_time   = time_q_vld_reg ? time_q_reg : 32'd0;
                    fresh_next[rd_idx_reg] = 1'b0;
                    rbusy_next           = 1'b1;
                end
            end
            OP_LAT_READ:
            begin
                sel_idx = lat_idx_reg;
                if (rbusy_reg)
                    res_next.status = ST_BUSY;
                else if (!lat_vld_reg || !fresh_reg[lat_idx_reg])
                    res_next.status = ST_EMPTY;
                else
                begin
                    rd_idx_next          = lat_idx_reg;
                    res_next.status      = ST_OK;
                    res_next.slot        = 3'(lat_idx_reg);
                    res_next.read_length = len_q_vld_reg ? len_q_reg : 16'd0;
                    fresh_next[lat_idx_reg] = 1'b0;
                    rbusy_next           = 1'b1;
                end
            end
            OP_FIN_READ:
            begin
                sel_idx = rd_idx_reg;
                if (rbusy_reg)
                begin
                    res_next.status    = ST_OK;
                    res_next.slot      = 3'(rd_idx_reg);
                    res_next.remaining = 3'(rem_val);
                    rd_idx_next        = next_slot(rd_idx_reg);
                    rbusy_next         = 1'b0;
                end
            end
            default:
            begin
                res_next.status = ST_INACTIVE;
            end
        endcase

        // base address only on successful grants and finish write
        if ((res_next.status == ST_OK) && (op_reg != OP_FIN_READ))
            res_next.base_address = 19'(base_prod);
    end

    assign base_prod = (IDX_W+16)'(sel_idx) * (IDX_W+16)'(slot_bytes);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            lat_idx_reg  <= '0;
            lat_vld_reg  <= 1'b0;
            wbusy_reg    <= 1'b0;
            rbusy_reg    <= 1'b0;
            fresh_reg    <= '0;
            len_vld_reg  <= '0;
            time_vld_reg <= '0;
        end
        else if (cmd.commit)
        begin
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            lat_idx_reg  <= lat_idx_next;
            lat_vld_reg  <= lat_vld_next;
            wbusy_reg    <= wbusy_next;
            rbusy_reg    <= rbusy_next;
            fresh_reg    <= fresh_next;
            len_vld_reg  <= len_vld_next;
            time_vld_reg <= time_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            result_reg <= res_next;
    end

    assign result = result_reg;

endmodule

// File: rtl/multi_slot_buffer_ring_manager_top.sv
// ----------------------------------------------------------------------------
// multi_slot_buffer_ring_manager_top
// Ring of buffer slots shared by one writer and one reader: slot grants,
// fill bookkeeping, ordered and latest reads.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake               Carries
// s_*       in   s_tvalid / s_tready     one request: op, length, stamp
// m_*       out  m_tvalid / m_tready     one result per request
// APB       in   psel & penable & pwrite slot_bytes register at address 0
//
// Each request passes through accept, slot table read (registered memory
// port), execute and load the result register. A new request is taken as soon
// as the execute cycle has moved its result into the output register, even if
// the previous result is still waiting. A stalled m_tready holds the execute
// step until the output register is free. Reset clears the indices, busy and
// fresh flags and the table valid bits; slot_bytes returns to 256.
//
module multi_slot_buffer_ring_manager_top
    import msbrm_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // write_length[15:0], write_time[47:16]
    input  logic [2:0]  s_tuser,   // op[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // status[1:0], slot[4:2], base_address[23:5],
                                   // read_length[39:24], read_time[71:40],
                                   // remaining[74:72], jumped_over[75], zero[79:76]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dp_cmd_t     cmd;
    result_t     result;
    logic [15:0] slot_bytes_reg;
    logic        reg_sel;

    // register index from the word address; offset bits ignored
    assign reg_sel = (paddr[2] == REG_SLOT_BYTES);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_bytes_reg <= SLOT_BYTES_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            slot_bytes_reg <= pwdata[15:0];
    end

    assign prdata = reg_sel ? {16'd0, slot_bytes_reg} : 32'd0;

    msbrm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    msbrm_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (s_tuser),
        .write_length (s_tdata[15:0]),
        .write_time   (s_tdata[47:16]),
        .slot_bytes   (slot_bytes_reg),
        .result       (result)
    );

    // result packing, first field lowest
    assign m_tdata = {4'd0,
                      result.jumped_over,
                      result.remaining,
                      result.read_time,
                      result.read_length,
                      result.base_address,
                      result.slot,
                      result.status};

endmodule
